// ===== sv/rdc_pkg.sv =====
// Shared constants and controller/datapath interface types for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int VALUE_BITS    = 31;
  localparam int MAX_DIGITS    = VALUE_BITS;
  localparam int RADIX_W       = 8;
  localparam int DIGIT_W       = 8;
  localparam int COUNT_FIELD_W = 5;
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W         = $clog2(MAX_DIGITS);
  localparam int STEP_W        = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new value, clear remainder and count
    logic step;   // one restoring division step
    logic store;  // write remainder as a digit, restart remainder
    logic next;   // advance the read index to the next lower digit
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic quot_zero;  // quotient left in the value register is zero
    logic rd_last;    // read index points at the least significant digit
  } sts_t;

endpackage

// ===== sv/radix_digit_converter_unit.sv =====
// Each digit comes from a bit-serial division over all VALUE_BITS bits of the value,
// then a store; every digit of an item is found before its first result beat.
// Throughput: one item at a time; results then leave at one beat a cycle while
// out_ready_i is high, and the next item is taken once the last beat has gone.
// Reset: radix returns to 10, controller idle, no result pending.
`timescale 1ns / 1ps

module radix_digit_converter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rdc_pkg::RADIX_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rdc_pkg::VALUE_BITS-1:0]       value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rdc_pkg::DIGIT_W-1:0]          digit_o,
  output logic                                 last_o,
  output logic [rdc_pkg::COUNT_FIELD_W-1:0]    digit_count_o
);

  rdc_pkg::cmd_t cmd;
  rdc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rdc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digit_o       (digit_o),
    .last_o        (last_o),
    .digit_count_o (digit_count_o)
  );

endmodule

// ===== sv/rdc_datapath.sv =====
// Datapath: radix register, bit-serial divider, digit store and readout.
`timescale 1ns / 1ps

module rdc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [rdc_pkg::RADIX_W-1:0]          cfg_data_i,
  input  logic [rdc_pkg::VALUE_BITS-1:0]       value_i,
  input  rdc_pkg::cmd_t                        cmd_i,
  output rdc_pkg::sts_t                        sts_o,
  output logic [rdc_pkg::DIGIT_W-1:0]          digit_o,
  output logic                                 last_o,
  output logic [rdc_pkg::COUNT_FIELD_W-1:0]    digit_count_o
);

  logic [rdc_pkg::RADIX_W-1:0]    radix_q, radix_d;
  logic [rdc_pkg::VALUE_BITS-1:0] n_q, n_d;
  logic [rdc_pkg::RADIX_W-1:0]    rem_q, rem_d;
  logic [rdc_pkg::CNT_W-1:0]      count_q, count_d;
  logic [rdc_pkg::IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [rdc_pkg::DIGIT_W-1:0]    digits_q [rdc_pkg::MAX_DIGITS];

  logic [rdc_pkg::RADIX_W:0]      rem_shift;
  logic [rdc_pkg::RADIX_W-1:0]    rem_sub;
  logic                           ge;

  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i) begin
      // clamp bases below two
      radix_d = (cfg_data_i < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN : cfg_data_i;
    end
  end

  assign rem_shift = {rem_q, n_q[rdc_pkg::VALUE_BITS-1]};
  // difference is below the radix whenever it is taken, so the low bits suffice
  assign rem_sub   = rem_shift[rdc_pkg::RADIX_W-1:0] - radix_q;
  assign ge        = (rem_shift >= {1'b0, radix_q});

  always_comb begin
    n_d      = n_q;
    rem_d    = rem_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.load) begin
      n_d     = value_i;
      rem_d   = '0;
      count_d = '0;
    end else if (cmd_i.step) begin
      rem_d = ge ? rem_sub : rem_shift[rdc_pkg::RADIX_W-1:0];
      n_d   = {n_q[rdc_pkg::VALUE_BITS-2:0], ge};
    end else if (cmd_i.store) begin
      rem_d    = '0;
      count_d  = count_q + 1'b1;
      rd_idx_d = count_q[rdc_pkg::IDX_W-1:0];
    end else if (cmd_i.next) begin
      rd_idx_d = rd_idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rdc_pkg::RADIX_RESET;
      count_q <= '0;
    end else begin
      radix_q <= radix_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    rem_q    <= rem_d;
    rd_idx_q <= rd_idx_d;
    if (cmd_i.store) begin
      digits_q[count_q[rdc_pkg::IDX_W-1:0]] <= rem_q;
    end
  end

  assign sts_o.quot_zero = (n_q == '0);
  assign sts_o.rd_last   = (rd_idx_q == '0);

  assign digit_o       = digits_q[rd_idx_q];
  assign last_o        = (rd_idx_q == '0);
  assign digit_count_o = rdc_pkg::COUNT_FIELD_W'(count_q);

`ifndef NO_ASSERTIONS
  a_radix_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    radix_q >= rdc_pkg::RADIX_MIN)
    else $error("radix register below minimum");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> count_q < rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS))
    else $error("digit store overflow");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> count_q == '0)
    else $error("count not cleared on load");
`endif

endmodule

// ===== sv/rdc_ctrl.sv =====
// Controller: sequences division steps per digit and the most-significant-first readout.
`timescale 1ns / 1ps

module rdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rdc_pkg::cmd_t cmd_o,
  input  rdc_pkg::sts_t sts_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_STORE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [rdc_pkg::STEP_W-1:0] STEP_LAST = rdc_pkg::STEP_W'(rdc_pkg::VALUE_BITS - 1);

  logic [1:0]                  state_q, state_d;
  logic [rdc_pkg::STEP_W-1:0]  step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        step_d      = '0;
        // stop once the quotient runs out
        state_d     = sts_i.quot_zero ? ST_EMIT : ST_DIV;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (sts_i.rd_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshakes open together");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == STEP_LAST) |=> state_q == ST_STORE)
    else $error("division did not finish after the last step");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIV && step_q == '0))
    else $error("accepted beat did not start division");
`endif

endmodule
